### rtl/teoc_pkg.sv
// shared types and constants for the ternary entry overlap checker
// no dependencies
package teoc_pkg;

	// parameter defaults
	localparam int MAX_ENTRIES_DEF = 256;
	localparam int KEY_FIELDS_DEF  = 4;
	localparam int KEY_WIDTH_DEF   = 64;

	// fixed port widths
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 7;
	localparam int VERD_W   = 3;
	localparam int MATCH_W  = 8;
	localparam int EIDX_W   = 9;
	localparam int WCFG_W   = 7;
	localparam int CFG_FLD  = 4;

	// register indexes
	localparam logic [CFG_AW-1:0] CFG_NUM_FIELDS = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_TERN_MAP   = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_DUP_ERR    = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_WIDTH_0    = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_WIDTH_1    = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_WIDTH_2    = 3'd5;
	localparam logic [CFG_AW-1:0] CFG_WIDTH_3    = 3'd6;

	// verdict codes
	localparam logic [VERD_W-1:0] V_UNIQUE    = 3'd0;
	localparam logic [VERD_W-1:0] V_DUP_ERR   = 3'd1;
	localparam logic [VERD_W-1:0] V_DUP_WARN  = 3'd2;
	localparam logic [VERD_W-1:0] V_COVERED   = 3'd3;
	localparam logic [VERD_W-1:0] V_MALFORMED = 3'd4;
	localparam logic [VERD_W-1:0] V_FULL      = 3'd5;

	// compare token passed along the cell row
	typedef struct packed {
		logic valid;
		logic dup;
		logic cov;
	} chain_tok_t;

endpackage

### rtl/ternary_entry_overlap_checker_unit.sv
// Ternary entry overlap checker: components are taken one per cycle while idle.
// A last component with stored entries starts a sweep: one stored entry enters the cell
// row per cycle, and each cell passes the token through its tok_s1 and tok_q registers.
// Malformed, full or first entries skip the sweep; an untaken result stalls intake.
// Reset clears the entry count, field position and flags; stored entries
// are not cleared and are only read once written.
module ternary_entry_overlap_checker_unit #(
	parameter int MAX_ENTRIES = teoc_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_FIELDS  = teoc_pkg::KEY_FIELDS_DEF,
	parameter int KEY_WIDTH   = teoc_pkg::KEY_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// start_table, key_value, key_mask_or_high from bit 0 up, zero padded
	input  logic [((2*KEY_WIDTH+1+7)/8)*8-1:0] s_tdata,
	// is_range
	input  logic                         s_tuser,
	input  logic                         s_tlast,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// verdict, matched_entry, entry_index from bit 0 up, zero padded
	output logic [23:0]                  m_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic                         cfg_we,
	input  logic [teoc_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [teoc_pkg::CFG_DW-1:0]  cfg_wdata
);
	import teoc_pkg::*;

	localparam int AW    = $clog2(MAX_ENTRIES);
	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int POS_W = $clog2(KEY_FIELDS + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SWEEP = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [2:0]        num_q;
	logic [3:0]        tmap_q;
	logic              duperr_q;
	logic [WCFG_W-1:0] wcfg_q [CFG_FLD];

	logic [1:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic [POS_W-1:0]  pos_q;
	logic              ovf_q;
	logic              store_q;
	logic [CW-1:0]     issue_q;
	logic [CW-1:0]     rcv_q;
	logic              found_q;
	logic [VERD_W-1:0] verd_q;
	logic [CW-1:0]     match_q;

	logic              out_valid_q;
	logic [VERD_W-1:0] out_verd_q;
	logic [MATCH_W-1:0] out_match_q;
	logic [EIDX_W-1:0] out_idx_q;

	logic              take;
	logic              start;
	logic              in_range;
	logic [KEY_WIDTH-1:0] in_value;
	logic [KEY_WIDTH-1:0] in_mask;
	logic [POS_W-1:0]  pos_base;
	logic [POS_W-1:0]  pos_n;
	logic              ovf_n;
	logic [CW-1:0]     cnt_base;
	logic              malformed;
	logic              full;
	logic              out_free;
	logic              store_we;
	logic              hit;

	chain_tok_t        tok   [KEY_FIELDS+1];
	logic [AW-1:0]     taddr [KEY_FIELDS+1];

	assign start    = s_tdata[0];
	assign in_value = s_tdata[KEY_WIDTH:1];
	assign in_mask  = s_tdata[2*KEY_WIDTH:KEY_WIDTH+1];
	assign in_range = s_tuser;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q    <= 3'd1;
			tmap_q   <= '0;
			duperr_q <= 1'b0;
			for (int i = 0; i < CFG_FLD; i++) begin
				wcfg_q[i] <= WCFG_W'(64);
			end
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_NUM_FIELDS: num_q    <= cfg_wdata[2:0];
				CFG_TERN_MAP:   tmap_q   <= cfg_wdata[3:0];
				CFG_DUP_ERR:    duperr_q <= cfg_wdata[0];
				CFG_WIDTH_0:    wcfg_q[0] <= cfg_wdata;
				CFG_WIDTH_1:    wcfg_q[1] <= cfg_wdata;
				CFG_WIDTH_2:    wcfg_q[2] <= cfg_wdata;
				CFG_WIDTH_3:    wcfg_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// component intake with table start applied first
	assign s_tready = (state_q == S_IDLE);
	assign take     = s_tvalid && s_tready;
	assign pos_base = start ? '0 : pos_q;
	assign cnt_base = start ? '0 : cnt_q;

	always_comb begin
		pos_n = pos_base;
		ovf_n = start ? 1'b0 : ovf_q;
		if (int'(pos_base) < KEY_FIELDS) begin
			pos_n = pos_base + POS_W'(1);
		end else begin
			ovf_n = 1'b1;
		end
	end

	assign malformed = ovf_n || (int'(pos_n) != int'(num_q));
	assign full      = int'(cnt_base) >= MAX_ENTRIES;
	assign out_free  = !out_valid_q || m_tready;
	assign store_we  = (state_q == S_DONE) && out_free && store_q;

	// row of field cells
	assign tok[0].valid = (state_q == S_SWEEP);
	assign tok[0].dup   = 1'b1;
	assign tok[0].cov   = 1'b1;
	assign taddr[0]     = issue_q[AW-1:0];

	for (genvar f = 0; f < KEY_FIELDS; f++) begin : g_cell
		logic [WCFG_W-1:0] wcfg;
		logic              tern;
		if (f < CFG_FLD) begin : g_cfg
			assign wcfg = wcfg_q[f];
			assign tern = tmap_q[f];
		end else begin : g_nocfg
			assign wcfg = '0;
			assign tern = 1'b0;
		end
		teoc_cell #(
			.MAX_ENTRIES(MAX_ENTRIES),
			.KEY_WIDTH  (KEY_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.pend_we    (take && (pos_base == POS_W'(f))),
			.pend_range (in_range),
			.pend_value (in_value),
			.pend_mask  (in_mask),
			.width_cfg  (wcfg),
			.ternary    (tern),
			.active     (POS_W'(f) < pos_q),
			.store_we   (store_we && (POS_W'(f) < pos_q)),
			.store_addr (cnt_q[AW-1:0]),
			.tok_in     (tok[f]),
			.addr_in    (taddr[f]),
			.tok_out    (tok[f+1]),
			.addr_out   (taddr[f+1])
		);
	end

	assign hit = tok[KEY_FIELDS].valid && !found_q
		&& (tok[KEY_FIELDS].dup || tok[KEY_FIELDS].cov);

	// sequencer: intake, sweep, drain, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			store_q <= 1'b0;
			issue_q <= '0;
			rcv_q   <= '0;
			found_q <= 1'b0;
			verd_q  <= V_UNIQUE;
			match_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						cnt_q   <= cnt_base;
						pos_q   <= pos_n;
						ovf_q   <= ovf_n;
						issue_q <= '0;
						rcv_q   <= '0;
						found_q <= 1'b0;
						match_q <= '0;
						verd_q  <= V_UNIQUE;
						store_q <= 1'b0;
						if (s_tlast) begin
							if (malformed) begin
								verd_q  <= V_MALFORMED;
								state_q <= S_DONE;
							end else if (full) begin
								verd_q  <= V_FULL;
								state_q <= S_DONE;
							end else if (cnt_base == '0) begin
								store_q <= 1'b1;
								state_q <= S_DONE;
							end else begin
								store_q <= 1'b1;
								state_q <= S_SWEEP;
							end
						end
					end
				end
				S_SWEEP: begin
					issue_q <= issue_q + CW'(1);
					if (issue_q == cnt_q - CW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (tok[KEY_FIELDS].valid && rcv_q == cnt_q - CW'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						pos_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
						if (store_q) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// first hit at the end of the row decides
			if (tok[KEY_FIELDS].valid) begin
				rcv_q <= rcv_q + CW'(1);
			end
			if (hit) begin
				found_q <= 1'b1;
				match_q <= rcv_q;
				if (tok[KEY_FIELDS].dup) begin
					verd_q <= duperr_q ? V_DUP_ERR : V_DUP_WARN;
				end else begin
					verd_q <= V_COVERED;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_verd_q  <= verd_q;
			out_match_q <= MATCH_W'(match_q);
			out_idx_q   <= EIDX_W'(cnt_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_idx_q, out_match_q, out_verd_q};

	// tokens leave the row only during a sweep or its drain
	a_tok_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		tok[KEY_FIELDS].valid |-> (state_q == S_SWEEP || state_q == S_DRAIN))
		else $error("compare token outside sweep");

	// a sweep never starts on an empty table
	a_sweep_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (cnt_q != '0))
		else $error("sweep with no stored entries");

	// stores only happen below capacity
	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		store_we |-> (int'(cnt_q) < MAX_ENTRIES))
		else $error("store into full table");

	// a result is loaded only when leaving the result state
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE && state_q == S_IDLE))
		else $error("result without finished entry");
endmodule

### rtl/teoc_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module teoc_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### rtl/teoc_cell.sv
// one key field cell: pending component, stored column and field compare
// depends on teoc_pkg and teoc_ram
module teoc_cell #(
	parameter int MAX_ENTRIES = teoc_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_WIDTH   = teoc_pkg::KEY_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pend_we,
	input  logic                           pend_range,
	input  logic [KEY_WIDTH-1:0]           pend_value,
	input  logic [KEY_WIDTH-1:0]           pend_mask,
	input  logic [teoc_pkg::WCFG_W-1:0]    width_cfg,
	input  logic                           ternary,
	input  logic                           active,
	input  logic                           store_we,
	input  logic [$clog2(MAX_ENTRIES)-1:0] store_addr,
	input  teoc_pkg::chain_tok_t           tok_in,
	input  logic [$clog2(MAX_ENTRIES)-1:0] addr_in,
	output teoc_pkg::chain_tok_t           tok_out,
	output logic [$clog2(MAX_ENTRIES)-1:0] addr_out
);
	import teoc_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int EW = 2 * KEY_WIDTH + 1;

	logic                 range_q;
	logic [KEY_WIDTH-1:0] value_q;
	logic [KEY_WIDTH-1:0] mask_q;
	logic [KEY_WIDTH-1:0] wmask;
	logic [KEY_WIDTH-1:0] cut_mask;
	logic [EW-1:0]        rd_word;
	logic                 r1;
	logic [KEY_WIDTH-1:0] v1;
	logic [KEY_WIDTH-1:0] m1;
	logic                 same;
	logic                 covf;
	chain_tok_t           tok_s1;
	logic [AW-1:0]        addr_s1;
	chain_tok_t           tok_q;
	logic [AW-1:0]        addr_q;

	// field width mask, zero or oversized width means full key width
	always_comb begin
		for (int b = 0; b < KEY_WIDTH; b++) begin
			if (width_cfg != '0 && int'(width_cfg) < KEY_WIDTH) begin
				wmask[b] = (b < int'(width_cfg));
			end else begin
				wmask[b] = 1'b1;
			end
		end
	end

	assign cut_mask = pend_mask & wmask;

	// pending component of this field
	always_ff @(posedge clk) begin
		if (pend_we) begin
			range_q <= pend_range;
			if (pend_range) begin
				value_q <= pend_value;
				mask_q  <= pend_mask;
			end else begin
				value_q <= pend_value & cut_mask;
				mask_q  <= cut_mask;
			end
		end
	end

	// stored column of this field
	teoc_ram #(
		.W(EW),
		.D(MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_addr),
		.wdata ({range_q, mask_q, value_q}),
		.raddr (addr_in),
		.rdata (rd_word)
	);

	assign r1 = rd_word[EW-1];
	assign m1 = rd_word[2*KEY_WIDTH-1:KEY_WIDTH];
	assign v1 = rd_word[KEY_WIDTH-1:0];

	// equal and covered tests against the stored entry
	assign same = (r1 == range_q) && (v1 == value_q) && (m1 == mask_q);
	assign covf = !r1 && !range_q && ternary && ((m1 & mask_q) == m1)
		&& ((v1 & m1) == (value_q & m1));

	// token stage while the ram read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_in;
	end

	// hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_s1.valid;
			if (active) begin
				tok_q.dup <= tok_s1.dup & same;
				tok_q.cov <= tok_s1.cov & (same | covf);
			end else begin
				tok_q.dup <= tok_s1.dup;
				tok_q.cov <= tok_s1.cov;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_s1;
	end

	assign tok_out  = tok_q;
	assign addr_out = addr_q;
endmodule

### verif/testbench.sv
// self-checking testbench for ternary_entry_overlap_checker_unit
// depends on rtl/teoc_pkg.sv and rtl/ternary_entry_overlap_checker_unit.sv
module testbench;
	import teoc_pkg::*;

	localparam int NSLOT   = 256;
	localparam int NFLD    = 4;
	localparam int SETTLE  = 2*NFLD + 16;
	localparam int WD_MAX  = 3000;

	// one key component as offered on the input stream
	typedef struct {
		logic        start;
		logic [63:0] val;
		logic [63:0] msk;
		logic        rng;
		logic        last;
		logic        has_exp;
		logic [2:0]  e_verd;
		logic [7:0]  e_match;
		logic [8:0]  e_idx;
	} comp_t;

	typedef struct packed {
		logic [8:0] idx;
		logic [7:0] matched;
		logic [2:0] verdict;
	} verdict_t;

	logic         clk;
	logic         arst_n;
	logic [135:0] s_tdata;
	logic         s_tuser;
	logic         s_tlast;
	logic         s_tvalid;
	logic         s_tready;
	logic [23:0]  m_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic         cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;

	ternary_entry_overlap_checker_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// predictor copy of the configuration
	int unsigned nf_cfg;
	int unsigned tmap_cfg;
	int unsigned duperr_cfg;
	int unsigned width_cfg[NFLD];

	// predictor copy of the entry table
	logic [63:0] tbl_val[NSLOT][NFLD];
	logic [63:0] tbl_msk[NSLOT][NFLD];
	logic        tbl_rng[NSLOT][NFLD];
	int unsigned tbl_count;
	logic [63:0] cur_val[NFLD];
	logic [63:0] cur_msk[NFLD];
	logic        cur_rng[NFLD];
	int unsigned cur_pos;
	bit          cur_ovf;

	verdict_t verdicts_due[$];
	comp_t    offered[$];
	int       fails;
	int       results_seen;
	bit       quiet;
	comp_t    prev_ent[NFLD];

	always #5 clk = ~clk;

	function automatic logic [63:0] field_width_mask(int f);
		int unsigned w;
		w = width_cfg[f];
		if (w == 0 || w > 64)
			w = 64;
		return (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	// take one accepted component, queue the verdict it causes
	task automatic predict_verdict(input comp_t c);
		verdict_t r;
		bit dup, cov;
		int f;
		logic [63:0] m;
		if (c.start) begin
			tbl_count = 0;
			cur_pos = 0;
			cur_ovf = 0;
		end
		if (cur_pos < NFLD) begin
			if (c.rng) begin
				cur_rng[cur_pos] = 1;
				cur_val[cur_pos] = c.val;
				cur_msk[cur_pos] = c.msk;
			end else begin
				m = c.msk & field_width_mask(cur_pos);
				cur_rng[cur_pos] = 0;
				cur_msk[cur_pos] = m;
				cur_val[cur_pos] = c.val & m;
			end
			cur_pos++;
		end else begin
			cur_ovf = 1;
		end
		if (!c.last)
			return;
		r.verdict = V_UNIQUE;
		r.matched = '0;
		r.idx = tbl_count[8:0];
		if (cur_ovf || cur_pos != nf_cfg) begin
			r.verdict = V_MALFORMED;
		end else begin
			for (int i = 0; i < tbl_count && i < NSLOT; i++) begin
				dup = 1;
				cov = 1;
				for (f = 0; f < cur_pos; f++) begin
					if (tbl_rng[i][f] == cur_rng[f] && tbl_val[i][f] == cur_val[f] &&
					    tbl_msk[i][f] == cur_msk[f])
						continue;
					dup = 0;
					if (!tbl_rng[i][f] && !cur_rng[f] && tmap_cfg[f] &&
					    (tbl_msk[i][f] & cur_msk[f]) == tbl_msk[i][f] &&
					    (tbl_val[i][f] & tbl_msk[i][f]) == (cur_val[f] & tbl_msk[i][f]))
						continue;
					cov = 0;
					break;
				end
				if (dup || cov) begin
					r.verdict = dup ? (duperr_cfg ? V_DUP_ERR : V_DUP_WARN) : V_COVERED;
					r.matched = i[7:0];
					break;
				end
			end
			if (tbl_count >= NSLOT) begin
				r.verdict = V_FULL;
				r.matched = '0;
			end else begin
				for (f = 0; f < cur_pos; f++) begin
					tbl_val[tbl_count][f] = cur_val[f];
					tbl_msk[tbl_count][f] = cur_msk[f];
					tbl_rng[tbl_count][f] = cur_rng[f];
				end
				tbl_count++;
			end
		end
		cur_pos = 0;
		cur_ovf = 0;
		if (c.has_exp) begin
			r.verdict = c.e_verd;
			r.matched = c.e_match;
			r.idx = c.e_idx;
		end
		verdicts_due = {verdicts_due, r};
	endtask

	// input side and output side monitors
	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_verdict(offered.pop_front());
			if (m_tvalid && m_tready) begin
				got = m_tdata[19:0];
				results_seen++;
				if (verdicts_due.size() == 0) begin
					$error("result with no verdict expected: %h", got);
					fails++;
				end else begin
					want = verdicts_due.pop_front();
					if (got.verdict !== want.verdict) begin
						$error("verdict: expected %0d actual %0d", want.verdict, got.verdict);
						fails++;
					end
					if (got.matched !== want.matched) begin
						$error("matched_entry: expected %0d actual %0d",
							want.matched, got.matched);
						fails++;
					end
					if (got.idx !== want.idx) begin
						$error("entry_index: expected %0d actual %0d", want.idx, got.idx);
						fails++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any accepted item
	int idle_cycles;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_MAX) begin
			$display("** ternary_entry_overlap_checker_unit: FAILED **");
			$finish;
		end
	end

	// result receiver with random stalls and one long hold-off
	initial begin
		int gap;
		bit held;
		held = 0;
		m_tready = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 17);
			if (!held && results_seen >= 40) begin
				gap = 400;
				held = 1;
			end
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic offer_item(input comp_t c);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		offered = {offered, c};
		s_tdata  <= {7'd0, c.msk, c.val, c.start};
		s_tuser  <= c.rng;
		s_tlast  <= c.last;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		wait (verdicts_due.size() == 0 && offered.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(input int unsigned nf, input int unsigned tm,
	                          input int unsigned de, input int unsigned w0,
	                          input int unsigned w1, input int unsigned w2,
	                          input int unsigned w3);
		int unsigned v[7];
		v = '{nf, tm, de, w0, w1, w2, w3};
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1;
			cfg_addr  <= i[CFG_AW-1:0];
			cfg_wdata <= v[i][CFG_DW-1:0];
			@(posedge clk);
		end
		cfg_we <= 0;
		nf_cfg = nf & 7;
		tmap_cfg = tm & 15;
		duperr_cfg = de & 1;
		width_cfg[0] = w0 & 127;
		width_cfg[1] = w1 & 127;
		width_cfg[2] = w2 & 127;
		width_cfg[3] = w3 & 127;
	endtask

	function automatic int unsigned pick_width();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 64;
			3: return 127;
			4: return 2;
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	// random component, often a copy of the previous entry so hits occur
	function automatic comp_t rand_comp(int f, bit wellformed);
		comp_t c;
		c = '{default: '0};
		if (wellformed && f < NFLD && $urandom_range(0, 99) < 40) begin
			c = prev_ent[f];
			if ($urandom_range(0, 2) == 0 && !c.rng)
				c.msk = '1;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: c.val = $urandom_range(0, 3);
				5, 6, 7:       c.val = {$urandom, $urandom};
				8:             c.val = '1;
				default:       c.val = '0;
			endcase
			c.rng = ($urandom_range(0, 5) == 0);
			if (c.rng)
				c.msk = c.val + $urandom_range(0, 3);
			else
				case ($urandom_range(0, 9))
					0, 1, 2: c.msk = '1;
					3:       c.msk = '0;
					4, 5, 6: c.msk = $urandom_range(0, 15);
					default: c.msk = {$urandom, $urandom};
				endcase
		end
		c.has_exp = 0;
		return c;
	endfunction

	// directed rows at reset settings: one field, 64 bits, no ternary, dup warns
	comp_t dir_rows[$] = '{
		'{1, 64'd0, 64'd0, 0, 1, 1, V_UNIQUE, 8'd0, 9'd0},
		'{0, '1, '1, 0, 1, 1, V_UNIQUE, 8'd0, 9'd1},
		'{0, '1, '1, 0, 1, 1, V_DUP_WARN, 8'd1, 9'd2},
		'{0, 64'd5, 64'd9, 1, 1, 1, V_UNIQUE, 8'd0, 9'd3},
		'{0, 64'd5, 64'd9, 1, 1, 1, V_DUP_WARN, 8'd3, 9'd4},
		'{0, 64'd5, 64'd10, 1, 1, 0, 0, 0, 0},
		'{0, 64'd1, 64'd1, 0, 0, 0, 0, 0, 0},
		'{0, 64'd2, 64'd3, 0, 1, 1, V_MALFORMED, 8'd0, 9'd6},
		'{0, 64'd1, 64'd1, 0, 0, 0, 0, 0, 0},
		'{0, 64'd2, 64'd2, 0, 0, 0, 0, 0, 0},
		'{0, 64'd3, 64'd3, 1, 0, 0, 0, 0, 0},
		'{0, 64'd4, 64'd4, 0, 0, 0, 0, 0, 0},
		'{0, 64'd5, 64'd5, 0, 1, 1, V_MALFORMED, 8'd0, 9'd6},
		'{0, 64'h8000_0000_0000_0000, '1, 0, 1, 0, 0, 0, 0},
		'{1, 64'd7, 64'd0, 0, 1, 1, V_UNIQUE, 8'd0, 9'd0},
		'{0, 64'd3, 64'd0, 0, 1, 1, V_DUP_WARN, 8'd0, 9'd1},
		'{0, 64'hA5A5_5A5A_F00F_0FF0, 64'h5A5A_A5A5_0FF0_F00F, 0, 1, 0, 0, 0, 0},
		'{0, 64'hA5A5_5A5A_F00F_0FF0, 64'h5A5A_A5A5_0FF0_F00F, 1, 1, 0, 0, 0, 0}
	};

	initial begin
		comp_t c;
		int items, budget, cnt;
		bit bad, fill;
		clk = 0;
		arst_n = 0;
		s_tdata = '0;
		s_tuser = 0;
		s_tlast = 0;
		s_tvalid = 0;
		cfg_we = 0;
		cfg_addr = '0;
		cfg_wdata = '0;
		fails = 0;
		results_seen = 0;
		quiet = 0;
		nf_cfg = 1;
		tmap_cfg = 0;
		duperr_cfg = 0;
		for (int f = 0; f < NFLD; f++) begin
			width_cfg[f] = 64;
			prev_ent[f] = '{default: '0};
		end
		tbl_count = 0;
		cur_pos = 0;
		cur_ovf = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part
		foreach (dir_rows[i])
			offer_item(dir_rows[i]);
		wait_drained();

		// random phases, each under its own register settings
		for (int ph = 0; ph < 13; ph++) begin
			fill = (ph == 2);
			quiet = (ph % 4 == 3);
			case (ph)
				0: write_regs(1, 0, 0, 64, 64, 64, 64);
				1: write_regs(4, 15, 1, 1, 1, 1, 1);
				2: write_regs(1, 1, 1, 64, 64, 64, 64);
				3: write_regs(4, 0, 0, 64, 64, 64, 64);
				default: write_regs($urandom_range(1, 4), $urandom_range(0, 15),
					$urandom_range(0, 1), pick_width(), pick_width(),
					pick_width(), pick_width());
			endcase
			budget = fill ? 300 : 110;
			items = 0;
			for (int e = 0; items < budget; e++) begin
				if (ph == 3 && e == 20)
					wait_drained();
				bad = !fill && $urandom_range(0, 6) == 0;
				cnt = bad ? $urandom_range(1, 6) : nf_cfg;
				for (int k = 0; k < cnt; k++) begin
					if (fill) begin
						c = '{default: '0};
						c.val = {$urandom, $urandom};
						c.msk = {$urandom, $urandom};
					end else begin
						c = rand_comp(k, !bad);
					end
					c.start = (e == 0 && k == 0) ||
						(!fill && k == 0 && $urandom_range(0, 59) == 0) ||
						(!fill && $urandom_range(0, 199) == 0);
					c.last = (k == cnt - 1);
					c.has_exp = 0;
					if (!bad && k < NFLD)
						prev_ent[k] = c;
					offer_item(c);
					items++;
				end
			end
			wait_drained();
		end

		if (fails == 0)
			$display("** ternary_entry_overlap_checker_unit: PASSED **");
		else
			$display("** ternary_entry_overlap_checker_unit: FAILED **");
		$finish;
	end

endmodule
